@@ sv/ksvm_pkg.sv @@
// ----------------------------------------------------------------------------
// ksvm_pkg
// Types, constants and the exp table shared by the kernel classifier modules.
// ----------------------------------------------------------------------------
package ksvm_pkg;

  localparam int unsigned MaxSv    = 128;
  localparam int unsigned MaxFeat  = 1024;
  localparam int unsigned ExpN     = 256;
  localparam int unsigned SvW      = $clog2(MaxSv);
  localparam int unsigned FeatW    = $clog2(MaxFeat);
  localparam int unsigned ExpW     = $clog2(ExpN);
  localparam int unsigned FcntW    = $clog2(MaxFeat + 1);
  localparam int unsigned ScntW    = $clog2(MaxSv + 1);

  localparam logic [1:0] OpSupFeat = 2'd0;
  localparam logic [1:0] OpCoef    = 2'd1;
  localparam logic [1:0] OpQuery   = 2'd2;

  localparam logic [2:0] CfgMode  = 3'd0;
  localparam logic [2:0] CfgGamma = 3'd1;
  localparam logic [2:0] CfgBias  = 3'd2;
  localparam logic [2:0] CfgFcnt  = 3'd3;
  localparam logic [2:0] CfgScnt  = 3'd4;

  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SV_START,
    ST_FEAT,
    ST_FEAT_DRAIN,
    ST_KERN_A,
    ST_KERN_B,
    ST_KERN_C,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic sv_clear;    // start a new support vector
    logic feat_step;   // issue read for feature index
    logic kern_a;
    logic kern_b;
    logic kern_c;
    logic acc_step;
    logic acc_init;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic feat_done;   // last feature issued
    logic sv_done;     // last support vector accumulated
    logic pipe_empty;
    logic no_feat;
    logic no_sv;
  } sts_t;

  typedef logic [ExpN-1:0][16:0] exp_rom_t;

  function automatic logic [16:0] exp_entry(input int unsigned i);
    logic [63:0] y, term;
    logic signed [63:0] sum;
    y    = (64'(i) * 64'd744261118) / 64'(ExpN);
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return 17'((64'(sum) + 64'd8192) >> 14);
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t r;
    for (int unsigned i = 0; i < ExpN; i++) r[i] = exp_entry(i);
    return r;
  endfunction

  // 2^(-i/ExpN) in unsigned Q1.16, fixed at elaboration
  localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

@@ sv/kernel_svm_decision.sv @@
// ----------------------------------------------------------------------------
// kernel_svm_decision
// Kernel SVM classifier, linear or radial basis kernel, Q16.16.
// ----------------------------------------------------------------------------
// channel   dir  handshake             content
// s_axis    in   s_tvalid/s_tready     op, slots, value, tlast = query_last
// m_axis    out  m_tvalid/m_tready     decision, class, saturated
// cfg       in   cfg_we_i              register index and data
// a final query item starts a decision pass paced by the single feature memory
// read port walking each support vector row.
// the result is held until taken; no request is accepted meanwhile.
// stores are not cleared by reset.
module kernel_svm_decision (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // operation, vector_slot, feature_slot, value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // decision_value, predicted_class, saturated
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic        kmode_q;
  logic [23:0] gamma_q;
  logic [31:0] bias_q;
  logic [10:0] fcnt_q;
  logic [7:0]  scnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmode_q <= 1'b0; gamma_q <= 24'd38779; bias_q <= '0; fcnt_q <= 11'd2; scnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ksvm_pkg::CfgMode:  kmode_q <= cfg_data_i[0];
        ksvm_pkg::CfgGamma: gamma_q <= cfg_data_i[23:0];
        ksvm_pkg::CfgBias:  bias_q  <= cfg_data_i;
        ksvm_pkg::CfgFcnt:  fcnt_q  <= cfg_data_i[10:0];
        ksvm_pkg::CfgScnt:  scnt_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [1:0]  op;
  logic [31:0] val;
  assign op  = s_axis_tdata[1:0];
  assign val = s_axis_tdata[50:19];

  logic busy, outv, acc;
  ksvm_pkg::cmd_t cmd;
  ksvm_pkg::sts_t sts;
  logic [31:0] dec;
  logic sat;

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  wire [ksvm_pkg::FcntW-1:0] nf = (fcnt_q > 11'(ksvm_pkg::MaxFeat)) ?
                                  11'(ksvm_pkg::MaxFeat) : fcnt_q;
  wire [ksvm_pkg::ScntW-1:0] ns = (scnt_q > 8'(ksvm_pkg::MaxSv)) ?
                                  8'(ksvm_pkg::MaxSv) : scnt_q;

  ksvm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && op == ksvm_pkg::OpQuery && s_axis_tlast),
    .sts_i(sts), .out_taken_i(m_axis_tready),
    .cmd_o(cmd), .busy_o(busy), .out_valid_o(outv)
  );

  ksvm_datapath u_dp (
    .clk_i, .rst_ni,
    .wr_en_i(acc), .wr_op_i(op), .wr_sv_i(s_axis_tdata[8:2]),
    .wr_feat_i(s_axis_tdata[18:9]), .wr_val_i(val),
    .kmode_i(kmode_q), .gamma_i(gamma_q), .bias_i(bias_q),
    .nfeat_i(nf), .nsv_i(ns), .cmd_i(cmd), .sts_o(sts), .dec_o(dec), .sat_o(sat)
  );

  assign m_axis_tvalid = outv;
  assign m_axis_tdata  = {6'd0, sat, !dec[31], dec};

endmodule

@@ sv/ksvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ksvm_ctrl
// Sequencer for the decision pass: walks support vectors and features.
// ----------------------------------------------------------------------------
module ksvm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ksvm_pkg::sts_t  sts_i,
  input  logic            out_taken_i,
  output ksvm_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            out_valid_o
);

  ksvm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ksvm_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ksvm_pkg::ST_IDLE: if (start_i) begin
        state_d = sts_i.no_sv ? ksvm_pkg::ST_OUT : ksvm_pkg::ST_SV_START;
      end
      ksvm_pkg::ST_SV_START: begin
        state_d = sts_i.no_feat ? ksvm_pkg::ST_FEAT_DRAIN : ksvm_pkg::ST_FEAT;
      end
      ksvm_pkg::ST_FEAT: if (sts_i.feat_done) state_d = ksvm_pkg::ST_FEAT_DRAIN;
      ksvm_pkg::ST_FEAT_DRAIN: if (sts_i.pipe_empty) state_d = ksvm_pkg::ST_KERN_A;
      ksvm_pkg::ST_KERN_A: state_d = ksvm_pkg::ST_KERN_B;
      ksvm_pkg::ST_KERN_B: state_d = ksvm_pkg::ST_KERN_C;
      ksvm_pkg::ST_KERN_C: state_d = ksvm_pkg::ST_ACC;
      ksvm_pkg::ST_ACC: begin
        state_d = sts_i.sv_done ? ksvm_pkg::ST_OUT : ksvm_pkg::ST_SV_START;
      end
      ksvm_pkg::ST_OUT: if (out_taken_i) state_d = ksvm_pkg::ST_IDLE;
      default: state_d = ksvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ksvm_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.acc_init = start_i;
      end
      ksvm_pkg::ST_SV_START: cmd_o.sv_clear = 1'b1;
      ksvm_pkg::ST_FEAT: cmd_o.feat_step = 1'b1;
      ksvm_pkg::ST_FEAT_DRAIN: ;
      ksvm_pkg::ST_KERN_A: cmd_o.kern_a = 1'b1;
      ksvm_pkg::ST_KERN_B: cmd_o.kern_b = 1'b1;
      ksvm_pkg::ST_KERN_C: cmd_o.kern_c = 1'b1;
      ksvm_pkg::ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        cmd_o.out_load = sts_i.sv_done;
      end
      ksvm_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/ksvm_datapath.sv @@
// ----------------------------------------------------------------------------
// ksvm_datapath
// Vector stores, kernel arithmetic and the saturating decision sum.
// ----------------------------------------------------------------------------
module ksvm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [1:0]                   wr_op_i,
  input  logic [6:0]                   wr_sv_i,
  input  logic [9:0]                   wr_feat_i,
  input  logic [31:0]                  wr_val_i,
  input  logic                         kmode_i,
  input  logic [23:0]                  gamma_i,
  input  logic [31:0]                  bias_i,
  input  logic [ksvm_pkg::FcntW-1:0]   nfeat_i,
  input  logic [ksvm_pkg::ScntW-1:0]   nsv_i,
  input  ksvm_pkg::cmd_t               cmd_i,
  output ksvm_pkg::sts_t               sts_o,
  output logic [31:0]                  dec_o,
  output logic                         sat_o
);

  logic [31:0] sup_mem [ksvm_pkg::MaxSv*ksvm_pkg::MaxFeat];
  logic [31:0] coef_mem [ksvm_pkg::MaxSv];
  logic [31:0] qry_mem [ksvm_pkg::MaxFeat];

  logic [ksvm_pkg::SvW-1:0]   sv_q;
  logic [ksvm_pkg::FcntW-1:0] f_q;
  logic [31:0] sup_rd_q, qry_rd_q, coef_rd_q;
  logic        v1_q, v2_q;
  logic signed [63:0] prod_q;
  // wide enough for a full row of extreme products
  logic signed [57:0] lacc_q;
  logic [57:0]        dacc_q;
  logic signed [32:0] acc_q;
  logic               sat_q;
  logic signed [32:0] kern_q;
  logic [63:0]        t_q;
  logic               kzero_q;
  logic [33:0]        u_q;
  logic [31:0]        dec_q;
  logic               sat_out_q;

  wire [ksvm_pkg::FeatW-1:0] fidx = f_q[ksvm_pkg::FeatW-1:0];

  // store writes and sequenced reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_op_i == ksvm_pkg::OpSupFeat)
      sup_mem[{wr_sv_i[ksvm_pkg::SvW-1:0], wr_feat_i[ksvm_pkg::FeatW-1:0]}] <= wr_val_i;
    if (wr_en_i && wr_op_i == ksvm_pkg::OpCoef)
      coef_mem[wr_sv_i[ksvm_pkg::SvW-1:0]] <= wr_val_i;
    if (wr_en_i && wr_op_i == ksvm_pkg::OpQuery)
      qry_mem[wr_feat_i[ksvm_pkg::FeatW-1:0]] <= wr_val_i;
    sup_rd_q  <= sup_mem[{sv_q, fidx}];
    qry_rd_q  <= qry_mem[fidx];
    coef_rd_q <= coef_mem[sv_q];
  end

  logic signed [32:0] diff;
  logic [31:0]        adiff;
  logic signed [63:0] fl_prod;
  assign diff  = $signed({sup_rd_q[31], sup_rd_q}) - $signed({qry_rd_q[31], qry_rd_q});
  assign adiff = diff[32] ? 32'(-diff) : diff[31:0];
  assign fl_prod = prod_q >>> 16;

  // kernel stage signals
  logic [71:0] dg;
  logic [16:0] ent;
  logic [15:0] n_w;
  logic [50:0] u_full;
  logic signed [65:0] ck;
  assign dg     = dacc_q[39:0] * gamma_i;
  assign u_full = 51'(t_q[23:0]) * 51'(ksvm_pkg::Log2eQ16);
  assign ent    = ksvm_pkg::ExpRom[u_q[15:16-ksvm_pkg::ExpW]];
  assign n_w    = u_q[31:16];
  assign ck     = $signed({{33{coef_rd_q[31]}}, coef_rd_q}) * $signed({{33{kern_q[32]}}, kern_q});
  wire signed [49:0] ck_sh = 50'(ck >>> 16);
  wire signed [49:0] acc_sum = 50'(acc_q) + ck_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0; f_q <= '0; v1_q <= 1'b0; v2_q <= 1'b0; sat_q <= 1'b0; sat_out_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.feat_step;
      v2_q <= v1_q;
      if (cmd_i.acc_init) begin sv_q <= '0; sat_q <= 1'b0; end
      if (cmd_i.sv_clear) f_q <= '0;
      if (cmd_i.feat_step) f_q <= f_q + 1'b1;
      if (cmd_i.acc_step) begin
        sv_q <= sv_q + 1'b1;
        if (acc_sum > 50'sd2147483647 || acc_sum < -50'sd2147483648) sat_q <= 1'b1;
      end
      if (cmd_i.kern_a && !kmode_i &&
          (lacc_q > 58'sd2147483647 || lacc_q < -58'sd2147483648)) sat_q <= 1'b1;
      if (cmd_i.out_load) begin
        sat_out_q <= sat_q ||
          (acc_sum > 50'sd2147483647 || acc_sum < -50'sd2147483648);
      end else if (cmd_i.acc_init && nsv_i == '0) sat_out_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) prod_q <= kmode_i ? $signed({32'd0, adiff}) * $signed({32'd0, adiff})
                                : $signed(sup_rd_q) * $signed(qry_rd_q);
    if (cmd_i.sv_clear) begin lacc_q <= '0; dacc_q <= '0; end
    else if (v2_q) begin
      lacc_q <= lacc_q + 58'(fl_prod);
      dacc_q <= dacc_q + 58'(prod_q[63:16]);
    end
    if (cmd_i.acc_init) acc_q <= $signed({bias_i[31], bias_i});
    if (cmd_i.kern_a) begin
      if (!kmode_i) begin
        if (lacc_q > 58'sd2147483647) kern_q <= 33'sd2147483647;
        else if (lacc_q < -58'sd2147483648) kern_q <= -33'sd2147483648;
        else kern_q <= 33'(lacc_q);
      end
      t_q     <= (gamma_i == '0) ? 64'd0 : 64'(dg >> 16);
      kzero_q <= !kmode_i ? 1'b0 : (gamma_i != '0 && dacc_q[57:40] != '0);
    end
    if (cmd_i.kern_b) begin
      u_q <= 34'(u_full >> 16);
      if (t_q[63:24] != '0) kzero_q <= kmode_i;
    end
    if (cmd_i.kern_c && kmode_i) begin
      if (kzero_q || n_w > 16'd16) kern_q <= '0;
      else kern_q <= $signed({16'd0, ent} >> n_w[4:0]);
    end
    if (cmd_i.acc_step) begin
      if (acc_sum > 50'sd2147483647) acc_q <= 33'sd2147483647;
      else if (acc_sum < -50'sd2147483648) acc_q <= -33'sd2147483648;
      else acc_q <= 33'(acc_sum);
    end
    if (cmd_i.out_load) begin
      if (acc_sum > 50'sd2147483647) dec_q <= 32'h7fffffff;
      else if (acc_sum < -50'sd2147483648) dec_q <= 32'h80000000;
      else dec_q <= acc_sum[31:0];
    end else if (cmd_i.acc_init && nsv_i == '0) dec_q <= bias_i;
  end

  assign sts_o.feat_done  = (f_q + 1'b1) >= nfeat_i;
  assign sts_o.sv_done    = (ksvm_pkg::ScntW'(sv_q) + 1'b1) >= nsv_i;
  assign sts_o.pipe_empty = !v1_q && !v2_q;
  assign sts_o.no_feat    = nfeat_i == '0;
  assign sts_o.no_sv      = nsv_i == '0;
  assign dec_o = dec_q;
  assign sat_o = sat_out_q;

endmodule

@@ tb/sv/tb_kernel_svm_decision.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kernel_svm_decision
// Self-checking bench for the kernel SVM classifier. Loads support vectors
// and coefficients and streams queries, both kernels, across many register
// settings. A Q16.16 scoring model predicts each decision, and every result
// is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_kernel_svm_decision;

  localparam logic [1:0] OpNone = 2'd3;  // unused code, block ignores it
  localparam int unsigned HoldCycles = 3000;

  typedef struct {
    logic [1:0]         op;
    logic [6:0]         vs;
    logic [9:0]         fs;
    logic signed [31:0] val;
    logic               last;
  } request_t;

  typedef struct {
    logic signed [31:0] dec;
    logic               cls;
    logic               sat;
  } decision_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // operation, vector_slot, feature_slot, value
  logic        s_axis_tlast;   // query_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // decision_value, predicted_class, saturated
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  kernel_svm_decision dut (.*);

  always #6 clk_i = ~clk_i;

  // scoring model state
  logic signed [31:0] sv_feat [ksvm_pkg::MaxSv*ksvm_pkg::MaxFeat];
  logic signed [31:0] sv_coef [ksvm_pkg::MaxSv];
  logic signed [31:0] query_vec [ksvm_pkg::MaxFeat];
  logic [31:0]        exp_lut [ksvm_pkg::ExpN];
  logic               mode_q;
  logic [23:0]        gamma_q;
  logic signed [31:0] bias_q;
  logic [10:0]        fcnt_q;
  logic [7:0]         scnt_q;

  // what the stimulus generator has written so far
  bit feat_known [ksvm_pkg::MaxSv*ksvm_pkg::MaxFeat];
  bit coef_known [ksvm_pkg::MaxSv];
  bit query_known [ksvm_pkg::MaxFeat];

  request_t  pending_reqs[$];
  decision_t expected_decisions[$];
  request_t  cur_req;
  int        gap_left;
  bit        tx_burst, rx_burst;
  bit        hold_trigger, hold_taken;
  int        stall_left;
  int        mismatches, checked, queries_sent, noise_sent, phases;

  function automatic longint clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint exp_neg(longint unsigned t);
    longint unsigned u, n, idx;
    if (t >= 64'd1 << 24) return 0;
    u = (t * 64'd94548) >> 16;
    n = u >> 16;
    if (n > 16) return 0;
    idx = ((u & 64'hFFFF) * ksvm_pkg::ExpN) >> 16;
    return longint'(exp_lut[idx] >> n);
  endfunction

  function automatic decision_t score_query();
    decision_t r;
    longint acc, k, lin, d;
    longint unsigned sq_dist, ad, t;
    bit sat;
    int nf, ns;
    sat = 1'b0;
    nf = (fcnt_q > ksvm_pkg::MaxFeat) ? ksvm_pkg::MaxFeat : fcnt_q;
    ns = (scnt_q > ksvm_pkg::MaxSv) ? ksvm_pkg::MaxSv : scnt_q;
    acc = longint'(bias_q);
    for (int s = 0; s < ns; s++) begin
      if (!mode_q) begin
        lin = 0;
        for (int f = 0; f < nf; f++)
          lin += (longint'(sv_feat[s*ksvm_pkg::MaxFeat+f]) * longint'(query_vec[f])) >>> 16;
        k = clip32(lin, sat);
      end else begin
        sq_dist = 0;
        for (int f = 0; f < nf; f++) begin
          d = longint'(sv_feat[s*ksvm_pkg::MaxFeat+f]) - longint'(query_vec[f]);
          ad = (d < 0) ? longint'(-d) : d;
          sq_dist += (ad * ad) >> 16;   // never reaches 64 bits
        end
        if (gamma_q == 0) k = exp_neg(0);
        else if (sq_dist >= (64'd1 << 40)) k = 0;
        else begin
          t = (sq_dist * gamma_q) >> 16;
          k = exp_neg(t);
        end
      end
      acc += (longint'(sv_coef[s]) * k) >>> 16;
      acc = clip32(acc, sat);
    end
    r.dec = acc[31:0];
    r.cls = (acc >= 0);
    r.sat = sat;
    return r;
  endfunction

  // apply an accepted request to the model
  function automatic void absorb_request(request_t q);
    case (q.op)
      ksvm_pkg::OpSupFeat: sv_feat[q.vs*ksvm_pkg::MaxFeat+q.fs] = q.val;
      ksvm_pkg::OpCoef:    sv_coef[q.vs] = q.val;
      ksvm_pkg::OpQuery: begin
        query_vec[q.fs] = q.val;
        if (q.last) expected_decisions = {expected_decisions, score_query()};
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      absorb_request(cur_req);
      g = draw_gap(tx_burst);
      if (g == 0 && pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata <= {5'b0, cur_req.val, cur_req.fs, cur_req.vs, cur_req.op};
        s_axis_tlast <= cur_req.last;
      end else begin
        s_axis_tvalid <= 1'b0;
        gap_left <= g;
      end
    end else if (!s_axis_tvalid) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata  <= {5'b0, cur_req.val, cur_req.fs, cur_req.vs, cur_req.op};
        s_axis_tlast  <= cur_req.last;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    decision_t exp_d;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_taken    <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (expected_decisions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_d = expected_decisions.pop_front();
          if (m_axis_tdata[31:0] !== exp_d.dec || m_axis_tdata[32] !== exp_d.cls ||
              m_axis_tdata[33] !== exp_d.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: decision %h class %b sat %b, expected %h %b %b",
                       m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                       exp_d.dec, exp_d.cls, exp_d.sat);
          end
        end
      end
      if (hold_trigger && !hold_taken) begin
        hold_taken    <= 1'b1;
        stall_left    <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        g = draw_gap(rx_burst);
        stall_left    <= g;
        m_axis_tready <= (g == 0);
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= (stall_left == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void push_req(logic [1:0] op, int vs, int fs, logic [31:0] val, bit last);
    request_t q;
    q.op = op; q.vs = vs[6:0]; q.fs = fs[9:0]; q.val = val; q.last = last;
    pending_reqs = {pending_reqs, q};
    if (op == ksvm_pkg::OpSupFeat) feat_known[q.vs*ksvm_pkg::MaxFeat+q.fs] = 1'b1;
    if (op == ksvm_pkg::OpCoef) coef_known[q.vs] = 1'b1;
    if (op == ksvm_pkg::OpQuery) begin
      query_known[q.fs] = 1'b1;
      if (last) queries_sent++;
    end
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // support rows and coefficients that a query will read get values first
  function automatic void load_vectors(int ns, int nf, bit refresh);
    for (int s = 0; s < ns; s++) begin
      for (int f = 0; f < nf; f++)
        if (refresh || !feat_known[s*ksvm_pkg::MaxFeat+f])
          push_req(ksvm_pkg::OpSupFeat, s, f, rand_value(), 0);
      if (refresh || !coef_known[s]) push_req(ksvm_pkg::OpCoef, s, 0, rand_value(), 0);
    end
  endfunction

  // a query: unknown entries always written, others three times in four (stale reuse)
  function automatic void send_query(int nf);
    int idx[$];
    for (int f = 0; f < nf; f++)
      if (!query_known[f] || $urandom_range(0, 3) != 0) idx = {idx, f};
    if (idx.size() == 0)
      idx = {idx, int'($urandom_range(0, nf > 0 ? nf - 1 : ksvm_pkg::MaxFeat - 1))};
    idx.shuffle();
    foreach (idx[i]) push_req(ksvm_pkg::OpQuery, $urandom_range(0, 127), idx[i], rand_value(),
                              i == idx.size() - 1);
  endfunction

  task automatic settle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_decisions.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_regs(bit m, logic [23:0] g, logic [31:0] b, logic [10:0] nf,
                          logic [7:0] ns);
    logic [31:0] vals [5];
    logic [2:0]  idxs [5];
    vals = '{32'(m), 32'(g), b, 32'(nf), 32'(ns)};
    idxs = '{ksvm_pkg::CfgMode, ksvm_pkg::CfgGamma, ksvm_pkg::CfgBias, ksvm_pkg::CfgFcnt,
             ksvm_pkg::CfgScnt};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mode_q = m; gamma_q = g; bias_q = b; fcnt_q = nf; scnt_q = ns;
    phases++;
  endtask

  initial begin
    longint unsigned y, term;
    longint sum;
    int nf, ns, budget;
    for (int i = 0; i < ksvm_pkg::ExpN; i++) begin
      y = (longint'(i) * 64'd744261118) / ksvm_pkg::ExpN;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = ((term * y) >> 30) / k;
        if (k % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      exp_lut[i] = 32'((longint'(sum) + 8192) >> 14);
    end
    mode_q = 0; gamma_q = 24'd38779; bias_q = 0; fcnt_q = 11'd2; scnt_q = 8'd0;
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: an ignored op, writes with tlast set, a query with no support vectors
    push_req(OpNone, 127, 1023, 32'hFFFF_FFFF, 1);
    push_req(ksvm_pkg::OpSupFeat, 0, 0, 32'h8000_0000, 1);
    push_req(ksvm_pkg::OpCoef, 127, 1023, 32'h7FFF_FFFF, 1);
    push_req(ksvm_pkg::OpQuery, 127, 0, 32'h8000_0000, 0);
    push_req(ksvm_pkg::OpQuery, 0, 1, 32'h7FFF_FFFF, 1);
    noise_sent += 3;
    settle();

    // linear, extreme data and bias so both sums clip
    set_regs(0, 24'd0, 32'h7FFF_FFFF, 11'd3, 8'd3);
    for (int s = 0; s < 3; s++) begin
      for (int f = 0; f < 3; f++) push_req(ksvm_pkg::OpSupFeat, s, f, 32'h7FFF_FFFF, 0);
      push_req(ksvm_pkg::OpCoef, s, 0, 32'h7FFF_FFFF, 0);
    end
    for (int f = 0; f < 3; f++) push_req(ksvm_pkg::OpQuery, 0, f, 32'h7FFF_FFFF, f == 2);
    for (int f = 0; f < 3; f++) push_req(ksvm_pkg::OpQuery, 0, f, 32'h8000_0000, f == 2);
    settle();
    set_regs(1, 24'd0, 32'h8000_0000, 11'd3, 8'd3);   // zero gamma gives kernel 1.0
    send_query(3);
    settle();
    set_regs(1, 24'hFF_FFFF, 32'd0, 11'd3, 8'd3);
    send_query(3);
    settle();
    // zero features: linear kernel 0, radial kernel 1.0
    set_regs(0, 24'd38779, 32'd65536, 11'd0, 8'd3);
    send_query(0);
    settle();
    set_regs(1, 24'd38779, 32'd65536, 11'd0, 8'd3);
    send_query(0);
    settle();
    // support vector count above the store size, one feature
    set_regs(1, 24'd38779, 32'h0, 11'd1, 8'd255);
    load_vectors(ksvm_pkg::MaxSv, 1, 0);
    send_query(1);
    settle();

    // random phases: mostly well-formed loads and queries, some noise
    budget = 600;
    while (budget > 0) begin
      nf = $urandom_range(1, 8);
      ns = $urandom_range(0, 8);
      set_regs($urandom_range(0, 1),
               $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 80000)),
               $urandom_range(0, 3) == 0 ? $urandom() :
                                           32'($signed($urandom_range(0, 262143)) - 131072),
               11'(nf), 8'(ns));
      tx_burst = (phases % 3 == 0);
      rx_burst = (phases % 4 == 1);
      if (phases == 12) hold_trigger = 1'b1;
      load_vectors(ns, nf, $urandom_range(0, 1));
      for (int n = 0; n < 12; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            push_req(ksvm_pkg::OpSupFeat, $urandom_range(0, 127), $urandom_range(0, 1023),
                     rand_value(), $urandom_range(0, 1));
            budget--;
          end
          1: begin
            push_req(ksvm_pkg::OpCoef, $urandom_range(0, 127), $urandom_range(0, 1023),
                     rand_value(), $urandom_range(0, 1));
            budget--;
          end
          2: begin
            push_req(OpNone, $urandom_range(0, 127), $urandom_range(0, 1023),
                     $urandom(), $urandom_range(0, 1));
            noise_sent++;
          end
          default: begin
            send_query(nf);
            budget -= nf;
          end
        endcase
      end
      settle();
    end

    repeat (200) @(posedge clk_i);
    $display("ran %0d register settings, %0d queries, %0d ignored requests",
             phases, queries_sent, noise_sent);
    $display("checked %0d results, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_decisions.size() == 0)
      $display("kernel_svm_decision regression: pass");
    else
      $display("kernel_svm_decision regression: fail");
    $finish;
  end

  initial begin
    #(64'd12 * 64'd4_000_000);
    $display("kernel_svm_decision regression: fail");
    $finish;
  end

endmodule

@@ kernel_svm_decision.f @@
sv/ksvm_pkg.sv
sv/ksvm_ctrl.sv
sv/ksvm_datapath.sv
sv/kernel_svm_decision.sv
tb/sv/tb_kernel_svm_decision.sv
